### sv/pmx_pkg.sv
// Shared types and constants for the GF(p) polynomial power block.
// Depends on nothing; imported by poly_mod_exp_gf_p.
package pmx_pkg;

  localparam int PrimeW   = 16;
  localparam int ExpW     = 32;
  localparam int NCoef    = 6;
  localparam int NProd    = 2 * NCoef - 1;
  localparam int DegW     = 3;
  localparam int IdxW     = 3;
  localparam int PIdxW    = 4;
  localparam int BitW     = 5;
  localparam int CfgIdxW  = 4;
  localparam int DivW     = 2 * PrimeW + 1;
  localparam int CntW     = 6;
  localparam int TW       = PrimeW + 2;

  localparam logic [DegW-1:0]    MaxDeg    = 3'd5;
  localparam logic [IdxW-1:0]    RedShift  = 3'd6;
  localparam logic [CntW-1:0]    DivLast   = 6'(DivW - 1);

  localparam logic [CfgIdxW-1:0] CfgPrime  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgDegree = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgCoef0  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgCoef5  = 4'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_MU, S_MU_WB, S_RED, S_RED_WB, S_CHECK,
    S_EUC, S_EUC_WB, S_EUC_T, S_INV, S_SCALE, S_SCALE_WB,
    S_EXP, S_SQ_CLR, S_SQ_MUL, S_SQ_MUL_WB, S_SQ_RED, S_SQ_RED_WB,
    S_SQ_COPY, S_LIN, S_LIN_WB, S_NEXT,
    S_MM1, S_MM2, S_MM3, S_MM4, S_DIV, S_DONE
  } pmx_state_e;

  typedef struct packed {
    logic [PrimeW-1:0] shift;
    logic [ExpW-1:0]   exponent;
  } pmx_in_t;

  typedef struct packed {
    logic [PrimeW-1:0] res_coef0;
    logic [PrimeW-1:0] res_coef1;
    logic [PrimeW-1:0] res_coef2;
    logic [PrimeW-1:0] res_coef3;
    logic [PrimeW-1:0] res_coef4;
    logic [PrimeW-1:0] res_coef5;
    logic              bad_modulus;
  } pmx_out_t;

endpackage

### sv/poly_mod_exp_gf_p.sv
// Top level: (x+a)^e mod f(x) over GF(p), square-and-multiply on one modular multiplier.
// Depends on pmx_pkg. Modular multiply: load, four Barrett steps, write-back.
// Setup first, then per exponent bit a squaring, plus a multiply by (x+a) when the bit is set.
// One request at a time; not ready while busy.
// Reset (async, active low) returns to idle with p=2, d=1, f(x)=x.
module poly_mod_exp_gf_p
  import pmx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmx_in_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmx_out_t            out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PrimeW-1:0]   cfg_data_i
);

  pmx_state_e state_q, state_d, ret_q, ret_d;

  logic [PrimeW-1:0] prime_q;
  logic [DegW-1:0]   degree_q;
  logic [PrimeW-1:0] coef_q [NCoef];

  logic [PrimeW-1:0] p_q, a_raw_q, a_q, inv_q;
  logic [DegW-1:0]   d_q;
  logic [ExpW-1:0]   e_q;
  logic              bad_q;
  logic [PrimeW-1:0] m_q    [NCoef];
  logic [PrimeW-1:0] pol_q  [NCoef];
  logic [PrimeW-1:0] prod_q [NProd];
  logic [IdxW-1:0]   i_q, j_q, k_q;
  logic [BitW-1:0]   n_q;

  logic [PrimeW-1:0]   op_a_q, op_b_q, mm_r_q;
  logic [ExpW-1:0]     mprod_q, mu_q, qhat_q, qp_q;

  logic [DivW-1:0]     dvd_q;
  logic [PrimeW-1:0]   dvs_q, rem_q;
  logic [CntW-1:0]     cnt_q;

  logic [PrimeW-1:0]   r0_q, r1_q;
  logic signed [TW-1:0] t0_q, t1_q;
  logic signed [TW:0]   qt_q;

  logic [PrimeW-1:0] p_eff;
  logic [DegW-1:0]   d_eff;
  logic [PIdxW-1:0]  ij_idx, id_idx;
  logic [BitW-1:0]   n_top;
  logic [PrimeW:0]   div_trial;
  logic              div_ge;
  logic [2*ExpW-1:0] mu_prod;
  logic [ExpW+PrimeW-1:0] qp_full;
  logic [ExpW-1:0]   red_diff;
  logic [PrimeW:0]   red_r;
  logic signed [2*TW-1:0] qt_full;
  logic signed [TW:0] inv_w;
  logic [PrimeW-1:0] top;

  function automatic logic [PrimeW-1:0] add_mod(input logic [PrimeW-1:0] x,
                                                input logic [PrimeW-1:0] y,
                                                input logic [PrimeW-1:0] p);
    logic [PrimeW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[PrimeW-1:0];
  endfunction

  assign p_eff  = (prime_q < 16'd2) ? 16'd2 : prime_q;
  assign d_eff  = (degree_q == '0) ? 3'd1 : ((degree_q > MaxDeg) ? MaxDeg : degree_q);
  assign ij_idx = {1'b0, i_q} + {1'b0, j_q};
  assign id_idx = {1'b0, i_q} + {1'b0, d_q};
  assign top    = m_q[d_q];

  always_comb begin
    n_top = '0;
    for (int b = 0; b < ExpW; b++) begin
      if (e_q[b]) n_top = BitW'(b);
    end
  end

  assign div_trial = {rem_q, dvd_q[DivW-1]};
  assign div_ge    = div_trial >= {1'b0, dvs_q};
  assign mu_prod   = (2*ExpW)'(mprod_q) * (2*ExpW)'(mu_q);
  assign qp_full   = (ExpW+PrimeW)'(qhat_q) * (ExpW+PrimeW)'(p_q);
  assign red_diff  = mprod_q - qp_q;
  assign red_r     = red_diff[PrimeW:0];
  assign qt_full   = (2*TW)'($signed({1'b0, dvd_q[PrimeW-1:0]})) * (2*TW)'(t1_q);
  assign inv_w     = (t0_q < 0) ? ($signed({t0_q[TW-1], t0_q}) + $signed({3'b0, p_q}))
                                : $signed({t0_q[TW-1], t0_q});

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_MU;
      S_MU:        begin state_d = S_DIV; ret_d = S_MU_WB; end
      S_DIV:       if (cnt_q == DivLast) state_d = ret_q;
      S_MU_WB:     state_d = S_RED;
      S_RED:       begin state_d = S_MM1; ret_d = S_RED_WB; end
      S_RED_WB:    state_d = (k_q == RedShift) ? S_CHECK : S_RED;
      S_CHECK: begin
        if (top == '0) state_d = S_DONE;
        else if (top == p_q - 16'd1) state_d = S_EXP;
        else state_d = S_EUC;
      end
      S_EUC: begin
        if (r1_q == '0) state_d = S_INV;
        else begin state_d = S_DIV; ret_d = S_EUC_WB; end
      end
      S_EUC_WB:    state_d = S_EUC_T;
      S_EUC_T:     state_d = S_EUC;
      S_INV:       state_d = S_SCALE;
      S_SCALE:     begin state_d = S_MM1; ret_d = S_SCALE_WB; end
      S_SCALE_WB:  state_d = (k_q == d_q) ? S_EXP : S_SCALE;
      S_EXP:       state_d = S_SQ_CLR;
      S_SQ_CLR:    state_d = S_SQ_MUL;
      S_SQ_MUL:    begin state_d = S_MM1; ret_d = S_SQ_MUL_WB; end
      S_SQ_MUL_WB: state_d = (i_q == d_q && j_q == d_q) ? S_SQ_RED : S_SQ_MUL;
      S_SQ_RED:    begin state_d = S_MM1; ret_d = S_SQ_RED_WB; end
      S_SQ_RED_WB: state_d = (i_q == '0 && j_q == d_q) ? S_SQ_COPY : S_SQ_RED;
      S_SQ_COPY:   state_d = e_q[n_q] ? S_LIN : S_NEXT;
      S_LIN:       begin state_d = S_MM1; ret_d = S_LIN_WB; end
      S_LIN_WB:    state_d = (i_q == '0) ? S_NEXT : S_LIN;
      S_NEXT:      state_d = (n_q == '0) ? S_DONE : S_SQ_CLR;
      S_MM1:       state_d = S_MM2;
      S_MM2:       state_d = S_MM3;
      S_MM3:       state_d = S_MM4;
      S_MM4:       state_d = ret_q;
      S_DONE:      if (out_ready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_DONE);
    cfg_ready_o = 1'b1;
    out_rsp_o.bad_modulus = bad_q;
    out_rsp_o.res_coef0 = (!bad_q)                    ? pol_q[0] : '0;
    out_rsp_o.res_coef1 = (!bad_q && d_q >= 3'd1)     ? pol_q[1] : '0;
    out_rsp_o.res_coef2 = (!bad_q && d_q >= 3'd2)     ? pol_q[2] : '0;
    out_rsp_o.res_coef3 = (!bad_q && d_q >= 3'd3)     ? pol_q[3] : '0;
    out_rsp_o.res_coef4 = (!bad_q && d_q >= 3'd4)     ? pol_q[4] : '0;
    out_rsp_o.res_coef5 = (!bad_q && d_q >= 3'd5)     ? pol_q[5] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      prime_q  <= 16'd2;
      degree_q <= 3'd1;
      for (int c = 0; c < NCoef; c++) coef_q[c] <= (c == 1) ? 16'd1 : 16'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgPrime) prime_q <= cfg_data_i;
        else if (cfg_index_i == CfgDegree) degree_q <= cfg_data_i[DegW-1:0];
        else if (cfg_index_i >= CfgCoef0 && cfg_index_i <= CfgCoef5)
          coef_q[IdxW'(cfg_index_i - CfgCoef0)] <= cfg_data_i;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_raw_q <= in_req_i.shift;
          e_q     <= in_req_i.exponent;
          p_q     <= p_eff;
          d_q     <= d_eff;
          bad_q   <= 1'b0;
        end
      end
      S_MU: begin
        dvd_q <= {1'b1, {(DivW-1){1'b0}}};
        dvs_q <= p_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? 16'(div_trial - {1'b0, dvs_q}) : div_trial[PrimeW-1:0];
        dvd_q <= {dvd_q[DivW-2:0], div_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      S_MU_WB: begin
        mu_q <= dvd_q[ExpW-1:0];
        k_q  <= '0;
      end
      S_RED: begin
        op_a_q <= (k_q == RedShift) ? a_raw_q : coef_q[k_q];
        op_b_q <= 16'd1;
      end
      S_RED_WB: begin
        if (k_q == RedShift) a_q <= mm_r_q;
        else m_q[k_q] <= mm_r_q;
        k_q <= k_q + 3'd1;
      end
      S_CHECK: begin
        if (top == '0) bad_q <= 1'b1;
        r0_q <= p_q;
        r1_q <= p_q - top;
        t0_q <= '0;
        t1_q <= 18'sd1;
      end
      S_EUC: begin
        dvd_q <= {{(DivW-PrimeW){1'b0}}, r0_q};
        dvs_q <= r1_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_EUC_WB: begin
        qt_q <= qt_full[TW:0];
        r0_q <= r1_q;
        r1_q <= rem_q;
      end
      S_EUC_T: begin
        t0_q <= t1_q;
        t1_q <= TW'($signed({t0_q[TW-1], t0_q}) - qt_q);
      end
      S_INV: begin
        inv_q <= (inv_w >= $signed({3'b0, p_q})) ? 16'(inv_w - $signed({3'b0, p_q}))
                                                  : inv_w[PrimeW-1:0];
        k_q   <= '0;
      end
      S_SCALE: begin
        op_a_q <= m_q[k_q];
        op_b_q <= inv_q;
      end
      S_SCALE_WB: begin
        m_q[k_q] <= mm_r_q;
        k_q      <= k_q + 3'd1;
      end
      S_EXP: begin
        for (int c = 0; c < NCoef; c++) pol_q[c] <= (c == 0) ? 16'd1 : 16'd0;
        n_q <= n_top;
      end
      S_SQ_CLR: begin
        for (int c = 0; c < NProd; c++) prod_q[c] <= '0;
        i_q <= '0;
        j_q <= '0;
      end
      S_SQ_MUL: begin
        op_a_q <= pol_q[i_q];
        op_b_q <= pol_q[j_q];
      end
      S_SQ_MUL_WB: begin
        prod_q[ij_idx] <= add_mod(prod_q[ij_idx], mm_r_q, p_q);
        if (j_q == d_q) begin
          j_q <= '0;
          if (i_q != d_q) i_q <= i_q + 3'd1;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      S_SQ_RED: begin
        op_a_q <= prod_q[id_idx];
        op_b_q <= m_q[j_q];
      end
      S_SQ_RED_WB: begin
        prod_q[ij_idx] <= add_mod(prod_q[ij_idx], mm_r_q, p_q);
        if (j_q == d_q) begin
          j_q <= '0;
          i_q <= i_q - 3'd1;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      S_SQ_COPY: begin
        for (int c = 0; c < NCoef; c++) begin
          if (DegW'(c) <= d_q) pol_q[c] <= prod_q[c];
        end
        i_q <= d_q;
      end
      S_LIN: begin
        op_a_q <= a_q;
        op_b_q <= pol_q[i_q];
      end
      S_LIN_WB: begin
        pol_q[i_q] <= add_mod((i_q == '0) ? 16'd0 : pol_q[i_q - 3'd1], mm_r_q, p_q);
        i_q <= i_q - 3'd1;
      end
      S_NEXT:  n_q <= n_q - 5'd1;
      S_MM1:   mprod_q <= ExpW'(op_a_q) * ExpW'(op_b_q);
      S_MM2:   qhat_q  <= mu_prod[2*ExpW-1:ExpW];
      S_MM3:   qp_q    <= qp_full[ExpW-1:0];
      S_MM4:   mm_r_q  <= (red_r >= {1'b0, p_q}) ? 16'(red_r - {1'b0, p_q})
                                                 : red_r[PrimeW-1:0];
      default: ;
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");

  a_mm_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MM4) |=> (mm_r_q < p_q)) else $error("multiplier result not reduced");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.bad_modulus) |->
      (out_rsp_o.res_coef0 == '0 && out_rsp_o.res_coef1 == '0 && out_rsp_o.res_coef2 == '0 &&
       out_rsp_o.res_coef3 == '0 && out_rsp_o.res_coef4 == '0 && out_rsp_o.res_coef5 == '0))
    else $error("bad modulus with nonzero result");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (d_q >= 3'd1 && d_q <= MaxDeg && p_q >= 16'd2))
    else $error("degree or prime out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dvs_q != '0)) else $error("divide by zero");

endmodule
